// ----- hdl/fam_pkg.sv -----
// Package with constants and types for the single-precision add/multiply core.
`default_nettype none
package fam_pkg;
  localparam int unsigned ExpMax = 255;
  localparam int unsigned ExpBias = 127;
  localparam logic [22:0] FracMask = 23'h7FFFFF;
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdMul = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] a;
    logic [31:0] b;
  } req_t;

  typedef struct packed {
    logic [31:0] word;
    logic        ovf;
  } res_t;

  // Leading-zero count of a 24-bit value; zero input gives 24.
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Packs sign, signed biased exponent and significand, flushing to zero at or below zero and saturating to infinity.
  function automatic res_t pack(input logic s, input logic signed [10:0] e,
                                input logic [22:0] f);
    res_t r;
    r.ovf = 1'b0;
    if (e <= 0) begin
      r.word = {s, 31'd0};
    end else if (e >= 11'sd255) begin
      r.word = {s, 8'hFF, 23'd0};
      r.ovf = 1'b1;
    end else begin
      r.word = {s, e[7:0], f};
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/float32_add_multiply_truncating_core.sv -----
// Top level of the truncating single-precision add/multiply core.
`default_nettype none
// Takes one request per cycle while not stalled (cmd, left_operand,
// right_operand) and gives one result per request through an input
// register, a single pass of combinational logic (one 24x24 multiplier or the
// align/add/normalise path) and a result register. Results are truncated with
// no rounding; overflow saturates to infinity and raises the flag. The block
// stalls only while both the input register and the result register are full
// and the result is not being taken.
module float32_add_multiply_truncating_core import fam_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,  // [31:0] left_operand, [63:32] right_operand
  input  wire logic        s_tuser,  // [0] cmd
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,  // [31:0] result_word
  output      logic        m_tuser   // [0] overflow_flag
);
  req_t req;
  logic req_valid;
  res_t res, res_next;
  logic res_valid;
  logic adv;

  assign adv = !res_valid || m_tready;
  assign s_tready = !req_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s_tready) req_valid <= s_tvalid;
      if (adv) res_valid <= req_valid;
    end
    if (s_tready && s_tvalid) begin
      req.cmd <= s_tuser;
      req.a <= s_tdata[31:0];
      req.b <= s_tdata[63:32];
    end
    if (adv && req_valid) res <= res_next;
  end

  assign m_tvalid = res_valid;
  assign m_tdata = res.word;
  assign m_tuser = res.ovf;

  logic za, zb, sa, sb;
  logic [7:0] ea, eb;
  logic [23:0] ma, mb;
  assign za = req.a[30:0] == 31'd0;
  assign zb = req.b[30:0] == 31'd0;
  assign sa = req.a[31];
  assign sb = req.b[31];
  assign ea = req.a[30:23];
  assign eb = req.b[30:23];
  assign ma = {1'b1, req.a[22:0] & FracMask};
  assign mb = {1'b1, req.b[22:0] & FracMask};

  logic [47:0] prod;
  logic [24:0] pm;
  logic signed [10:0] pe;
  res_t mul_r, add_r;
  assign prod = ma * mb;
  always_comb begin
    pm = prod[47:23];
    pe = 11'(signed'({3'd0, ea})) + 11'(signed'({3'd0, eb})) - 11'sd127;
    if (pm[24]) begin
      pm = pm >> 1;
      pe = pe + 11'sd1;
    end
    if (za || zb) begin
      mul_r.word = {sa ^ sb, 31'd0};
      mul_r.ovf = 1'b0;
    end else begin
      mul_r = pack(sa ^ sb, pe, pm[22:0]);
    end
  end

  logic swap, xs, ys;
  logic [7:0] xe, ye, d;
  logic [23:0] xm, ym, ysh, dm;
  logic [24:0] sum;
  logic [4:0] lz;
  logic signed [10:0] ae;
  always_comb begin
    swap = ea < eb;
    xs = swap ? sb : sa;
    ys = swap ? sa : sb;
    xe = swap ? eb : ea;
    ye = swap ? ea : eb;
    xm = swap ? mb : ma;
    ym = swap ? ma : mb;
    d = xe - ye;
    ysh = (d >= 8'd32) ? 24'd0 : ym >> d[4:0];
    sum = {1'b0, xm} + {1'b0, ysh};
    dm = (xm > ysh) ? xm - ysh : ysh - xm;
    lz = lzc24(dm);
    ae = 11'(signed'({3'd0, xe}));
    if (za && zb) begin
      add_r.word = {sa & sb, 31'd0};
      add_r.ovf = 1'b0;
    end else if (za) begin
      add_r.word = req.b;
      add_r.ovf = 1'b0;
    end else if (zb) begin
      add_r.word = req.a;
      add_r.ovf = 1'b0;
    end else if (xs == ys) begin
      if (sum[24]) add_r = pack(xs, ae + 11'sd1, sum[23:1]);
      else add_r = pack(xs, ae, sum[22:0]);
    end else if (xm == ysh) begin
      add_r.word = 32'd0;
      add_r.ovf = 1'b0;
    end else begin
      add_r = pack((xm > ysh) ? xs : ys, ae - 11'(signed'({6'd0, lz})),
                   23'(dm << lz));
    end
  end

  assign res_next = (req.cmd == CmdMul) ? mul_r : add_r;
endmodule
`default_nettype wire
